// ----- hdl/dpb_pkg.sv -----
package dpb_pkg;

  localparam int RAW_W     = 16;
  localparam int SCALE_W   = 24;
  localparam int WIDTH_W   = 13;
  localparam int COEF_W    = 32;
  localparam int OUT_W     = 32;
  localparam int CNT_W     = 12;
  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  localparam int D_W      = RAW_W + SCALE_W;
  localparam int S_W      = 46;
  localparam int MAG_W    = S_W - 1;
  localparam int MUL_A_W  = 33;
  localparam int MUL_B_W  = 25;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;
  localparam int ACC_W    = 86;
  localparam int CFG_IDX_W = 3;

  localparam logic [SCALE_W-1:0] METRE_SCALE_RST = 24'd16777;
  localparam logic [WIDTH_W-1:0] IMAGE_WIDTH_RST = 13'd640;
  localparam logic [COEF_W-1:0]  INV_F_RST       = 32'h1000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CALIB_LOADED = 3'd0,
    REG_METRE_SCALE  = 3'd1,
    REG_IMAGE_WIDTH  = 3'd2,
    REG_INV_FX       = 3'd3,
    REG_SKEW_TERM    = 3'd4,
    REG_X_OFFSET     = 3'd5,
    REG_INV_FY       = 3'd6,
    REG_Y_OFFSET     = 3'd7
  } cfg_reg_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_D, ST_FX, ST_SK, ST_FY, ST_SY, ST_ABS,
    ST_X0, ST_X1, ST_X2, ST_X3, ST_X4, ST_XR,
    ST_Y0, ST_Y1, ST_Y2, ST_Y3, ST_Y4, ST_YR,
    ST_EMIT
  } state_t;

  typedef enum logic [3:0] {
    MUL_NONE, MUL_D, MUL_FX, MUL_SK, MUL_FY,
    MUL_LL, MUL_LH, MUL_HL, MUL_HH
  } mul_sel_t;

  typedef enum logic [3:0] {
    ACC_HOLD, ACC_D, ACC_SX_INIT, ACC_SX_ADD, ACC_SY_INIT, ACC_ABS,
    ACC_INIT, ACC_ADD24, ACC_ADD32, ACC_ADD56, ACC_RND
  } acc_sel_t;

  typedef struct packed {
    logic     take;
    mul_sel_t mul_sel;
    acc_sel_t acc_sel;
    logic     coord_y;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic calib;
    logic raw_nz;
    logic last;
  } sts_t;

endpackage

// ----- hdl/dpb_ifs.sv -----
interface dpb_pixel_if;
  logic                          valid;
  logic                          ready;
  logic [dpb_pkg::RAW_W-1:0]     depth_raw;
  logic                          frame_last;

  modport source (output valid, depth_raw, frame_last, input ready);
  modport sink (input valid, depth_raw, frame_last, output ready);
endinterface

interface dpb_point_if;
  logic                              valid;
  logic                              ready;
  logic signed [dpb_pkg::OUT_W-1:0]  point_x;
  logic signed [dpb_pkg::OUT_W-1:0]  point_y;
  logic signed [dpb_pkg::OUT_W-1:0]  point_z;
  logic                              point_valid;
  logic                              frame_end;

  modport source (output valid, point_x, point_y, point_z, point_valid, frame_end,
                  input ready);
  modport sink (input valid, point_x, point_y, point_z, point_valid, frame_end,
                output ready);
endinterface

// ----- hdl/depth_pixel_backprojection_unit.sv -----
// Back-projects a raster stream of raw depth pixels into camera-frame points (signed
// Q16.16 metres, saturated), one pixel beat at a time. A pixel is dropped when it is
// zero or when calibration is not loaded, but a zero pixel that closes the frame is
// emitted as an empty point once calibration is loaded. A nonzero pixel is stepped by
// the sequencer through the single shared 33x25-bit multiplier: the depth scale, the
// three matrix products and four partial products each for x and y. The result
// register lets the next pixel be taken while a point still waits downstream.
module depth_pixel_backprojection_unit (
  input  logic                            clk,
  input  logic                            rst,
  dpb_pixel_if.sink                       pixel,
  dpb_point_if.source                     point,
  input  logic                            cfg_we,
  input  logic [dpb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dpb_pkg::COEF_W-1:0]      cfg_data
);

  dpb_pkg::cmd_t cmd;
  dpb_pkg::sts_t sts;

  dpb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pixel.valid),
    .in_ready  (pixel.ready),
    .out_valid (point.valid),
    .out_ready (point.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  dpb_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .depth_raw   (pixel.depth_raw),
    .frame_last  (pixel.frame_last),
    .cmd         (cmd),
    .sts         (sts),
    .point_x     (point.point_x),
    .point_y     (point.point_y),
    .point_z     (point.point_z),
    .point_valid (point.point_valid),
    .frame_end   (point.frame_end)
  );

endmodule

// ----- hdl/dpb_ctrl.sv -----
module dpb_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  dpb_pkg::sts_t sts,
  output dpb_pkg::cmd_t cmd
);

  dpb_pkg::state_t state;
  dpb_pkg::state_t state_next;
  logic            out_free;
  logic            take;

  assign out_free = !out_valid || out_ready;
  assign take     = (state == dpb_pkg::ST_IDLE) && in_valid;
  assign in_ready = (state == dpb_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dpb_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      dpb_pkg::ST_IDLE: begin
        if (take && sts.calib && sts.raw_nz) begin
          state_next = dpb_pkg::ST_D;
        end else if (take && sts.calib && sts.last) begin
          state_next = dpb_pkg::ST_EMIT;
        end
      end
      dpb_pkg::ST_D:   state_next = dpb_pkg::ST_FX;
      dpb_pkg::ST_FX:  state_next = dpb_pkg::ST_SK;
      dpb_pkg::ST_SK:  state_next = dpb_pkg::ST_FY;
      dpb_pkg::ST_FY:  state_next = dpb_pkg::ST_SY;
      dpb_pkg::ST_SY:  state_next = dpb_pkg::ST_ABS;
      dpb_pkg::ST_ABS: state_next = dpb_pkg::ST_X0;
      dpb_pkg::ST_X0:  state_next = dpb_pkg::ST_X1;
      dpb_pkg::ST_X1:  state_next = dpb_pkg::ST_X2;
      dpb_pkg::ST_X2:  state_next = dpb_pkg::ST_X3;
      dpb_pkg::ST_X3:  state_next = dpb_pkg::ST_X4;
      dpb_pkg::ST_X4:  state_next = dpb_pkg::ST_XR;
      dpb_pkg::ST_XR:  state_next = dpb_pkg::ST_Y0;
      dpb_pkg::ST_Y0:  state_next = dpb_pkg::ST_Y1;
      dpb_pkg::ST_Y1:  state_next = dpb_pkg::ST_Y2;
      dpb_pkg::ST_Y2:  state_next = dpb_pkg::ST_Y3;
      dpb_pkg::ST_Y3:  state_next = dpb_pkg::ST_Y4;
      dpb_pkg::ST_Y4:  state_next = dpb_pkg::ST_YR;
      dpb_pkg::ST_YR:  state_next = dpb_pkg::ST_EMIT;
      dpb_pkg::ST_EMIT: begin
        if (out_free) begin
          state_next = dpb_pkg::ST_IDLE;
        end
      end
      default: state_next = dpb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.take     = take;
    cmd.mul_sel  = dpb_pkg::MUL_NONE;
    cmd.acc_sel  = dpb_pkg::ACC_HOLD;
    unique case (state)
      dpb_pkg::ST_IDLE: ;
      dpb_pkg::ST_D:   cmd.mul_sel = dpb_pkg::MUL_D;
      dpb_pkg::ST_FX: begin
        cmd.mul_sel = dpb_pkg::MUL_FX;
        cmd.acc_sel = dpb_pkg::ACC_D;
      end
      dpb_pkg::ST_SK: begin
        cmd.mul_sel = dpb_pkg::MUL_SK;
        cmd.acc_sel = dpb_pkg::ACC_SX_INIT;
      end
      dpb_pkg::ST_FY: begin
        cmd.mul_sel = dpb_pkg::MUL_FY;
        cmd.acc_sel = dpb_pkg::ACC_SX_ADD;
      end
      dpb_pkg::ST_SY:  cmd.acc_sel = dpb_pkg::ACC_SY_INIT;
      dpb_pkg::ST_ABS: cmd.acc_sel = dpb_pkg::ACC_ABS;
      dpb_pkg::ST_X0:  cmd.mul_sel = dpb_pkg::MUL_LL;
      dpb_pkg::ST_X1: begin
        cmd.mul_sel = dpb_pkg::MUL_LH;
        cmd.acc_sel = dpb_pkg::ACC_INIT;
      end
      dpb_pkg::ST_X2: begin
        cmd.mul_sel = dpb_pkg::MUL_HL;
        cmd.acc_sel = dpb_pkg::ACC_ADD24;
      end
      dpb_pkg::ST_X3: begin
        cmd.mul_sel = dpb_pkg::MUL_HH;
        cmd.acc_sel = dpb_pkg::ACC_ADD32;
      end
      dpb_pkg::ST_X4:  cmd.acc_sel = dpb_pkg::ACC_ADD56;
      dpb_pkg::ST_XR:  cmd.acc_sel = dpb_pkg::ACC_RND;
      dpb_pkg::ST_Y0: begin
        cmd.coord_y = 1'b1;
        cmd.mul_sel = dpb_pkg::MUL_LL;
      end
      dpb_pkg::ST_Y1: begin
        cmd.coord_y = 1'b1;
        cmd.mul_sel = dpb_pkg::MUL_LH;
        cmd.acc_sel = dpb_pkg::ACC_INIT;
      end
      dpb_pkg::ST_Y2: begin
        cmd.coord_y = 1'b1;
        cmd.mul_sel = dpb_pkg::MUL_HL;
        cmd.acc_sel = dpb_pkg::ACC_ADD24;
      end
      dpb_pkg::ST_Y3: begin
        cmd.coord_y = 1'b1;
        cmd.mul_sel = dpb_pkg::MUL_HH;
        cmd.acc_sel = dpb_pkg::ACC_ADD32;
      end
      dpb_pkg::ST_Y4: begin
        cmd.coord_y = 1'b1;
        cmd.acc_sel = dpb_pkg::ACC_ADD56;
      end
      dpb_pkg::ST_YR: begin
        cmd.coord_y = 1'b1;
        cmd.acc_sel = dpb_pkg::ACC_RND;
      end
      dpb_pkg::ST_EMIT: cmd.out_load = out_free;
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  a_drop_uncal: assert property (@(posedge clk) disable iff (rst)
    take && !sts.calib |=> state == dpb_pkg::ST_IDLE)
    else $error("uncalibrated beat left idle");

  a_start_calc: assert property (@(posedge clk) disable iff (rst)
    take && sts.calib && sts.raw_nz |=> state == dpb_pkg::ST_D)
    else $error("nonzero pixel did not start the sequence");

  a_zero_last: assert property (@(posedge clk) disable iff (rst)
    take && sts.calib && !sts.raw_nz && sts.last |=> state == dpb_pkg::ST_EMIT)
    else $error("empty frame-end beat not emitted");

  a_emit: assert property (@(posedge clk) disable iff (rst)
    state == dpb_pkg::ST_EMIT && out_free |=> out_valid && state == dpb_pkg::ST_IDLE)
    else $error("emit did not present a result");
`endif

endmodule

// ----- hdl/dpb_datapath.sv -----
module dpb_datapath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [dpb_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [dpb_pkg::COEF_W-1:0]            cfg_data,
  input  logic [dpb_pkg::RAW_W-1:0]             depth_raw,
  input  logic                                  frame_last,
  input  dpb_pkg::cmd_t                         cmd,
  output dpb_pkg::sts_t                         sts,
  output logic signed [dpb_pkg::OUT_W-1:0]      point_x,
  output logic signed [dpb_pkg::OUT_W-1:0]      point_y,
  output logic signed [dpb_pkg::OUT_W-1:0]      point_z,
  output logic                                  point_valid,
  output logic                                  frame_end
);

  logic                                calib_loaded;
  logic [dpb_pkg::SCALE_W-1:0]         metre_scale;
  logic [dpb_pkg::WIDTH_W-1:0]         image_width;
  logic [dpb_pkg::COEF_W-1:0]          inv_fx;
  logic [dpb_pkg::COEF_W-1:0]          skew_term;
  logic [dpb_pkg::COEF_W-1:0]          x_offset;
  logic [dpb_pkg::COEF_W-1:0]          inv_fy;
  logic [dpb_pkg::COEF_W-1:0]          y_offset;

  logic [dpb_pkg::CNT_W-1:0]           column_count;
  logic [dpb_pkg::CNT_W-1:0]           row_count;
  logic [dpb_pkg::CNT_W-1:0]           column_count_next;
  logic [dpb_pkg::CNT_W-1:0]           row_count_next;

  logic [dpb_pkg::RAW_W-1:0]           raw_op;
  logic [dpb_pkg::CNT_W-1:0]           col_op;
  logic [dpb_pkg::CNT_W-1:0]           row_op;
  logic                                last_op;
  logic                                ptv_op;

  logic signed [dpb_pkg::MUL_A_W-1:0]  mul_a;
  logic signed [dpb_pkg::MUL_B_W-1:0]  mul_b;
  logic signed [dpb_pkg::PROD_W-1:0]   prod;
  logic [dpb_pkg::D_W-1:0]             d_val;
  logic signed [dpb_pkg::S_W-1:0]      sx;
  logic signed [dpb_pkg::S_W-1:0]      sy;
  logic [dpb_pkg::MAG_W-1:0]           mag_x;
  logic [dpb_pkg::MAG_W-1:0]           mag_y;
  logic                                neg_x;
  logic                                neg_y;
  logic [dpb_pkg::ACC_W-1:0]           acc;
  logic [dpb_pkg::OUT_W-1:0]           res_x;
  logic [dpb_pkg::OUT_W-1:0]           res_y;
  logic [dpb_pkg::OUT_W-1:0]           res_z;

  logic [dpb_pkg::MAG_W-1:0]           mag_sel;
  logic [dpb_pkg::ACC_W-1:0]           part;
  logic [dpb_pkg::WIDTH_W-1:0]         width_eff;
  logic [dpb_pkg::WIDTH_W-1:0]         col_inc;
  logic [dpb_pkg::WIDTH_W-1:0]         row_inc;
  logic [dpb_pkg::D_W:0]               z_sum;
  logic                                rnd_neg;
  logic                                rnd_sat;
  logic [dpb_pkg::OUT_W-1:0]           rnd_q;
  logic [dpb_pkg::OUT_W-1:0]           rnd_val;

  assign sts.calib  = calib_loaded;
  assign sts.raw_nz = |depth_raw;
  assign sts.last   = frame_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      calib_loaded <= 1'b0;
      metre_scale  <= dpb_pkg::METRE_SCALE_RST;
      image_width  <= dpb_pkg::IMAGE_WIDTH_RST;
      inv_fx       <= dpb_pkg::INV_F_RST;
      skew_term    <= '0;
      x_offset     <= '0;
      inv_fy       <= dpb_pkg::INV_F_RST;
      y_offset     <= '0;
    end else if (cfg_we) begin
      unique case (dpb_pkg::cfg_reg_t'(cfg_index))
        dpb_pkg::REG_CALIB_LOADED: calib_loaded <= cfg_data[0];
        dpb_pkg::REG_METRE_SCALE:  metre_scale  <= cfg_data[dpb_pkg::SCALE_W-1:0];
        dpb_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data[dpb_pkg::WIDTH_W-1:0];
        dpb_pkg::REG_INV_FX:       inv_fx       <= cfg_data;
        dpb_pkg::REG_SKEW_TERM:    skew_term    <= cfg_data;
        dpb_pkg::REG_X_OFFSET:     x_offset     <= cfg_data;
        dpb_pkg::REG_INV_FY:       inv_fy       <= cfg_data;
        dpb_pkg::REG_Y_OFFSET:     y_offset     <= cfg_data;
        default: ;
      endcase
    end
  end

  // raster position: wrap the column at the row end, clear both at frame end
  always_comb begin
    width_eff = (image_width == '0) ? dpb_pkg::WIDTH_W'(1) : image_width;
    col_inc   = {1'b0, column_count} + dpb_pkg::WIDTH_W'(1);
    row_inc   = {1'b0, row_count} + dpb_pkg::WIDTH_W'(1);
    if (frame_last) begin
      column_count_next = '0;
      row_count_next    = '0;
    end else if (col_inc >= width_eff || col_inc >= dpb_pkg::WIDTH_W'(dpb_pkg::MAX_WIDTH)) begin
      column_count_next = '0;
      row_count_next    = (row_inc >= dpb_pkg::WIDTH_W'(dpb_pkg::MAX_HEIGHT))
                          ? '0 : row_inc[dpb_pkg::CNT_W-1:0];
    end else begin
      column_count_next = col_inc[dpb_pkg::CNT_W-1:0];
      row_count_next    = row_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (cmd.take) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      raw_op  <= depth_raw;
      col_op  <= column_count;
      row_op  <= row_count;
      last_op <= frame_last;
      ptv_op  <= |depth_raw;
    end
  end

  always_comb begin
    mag_sel = cmd.coord_y ? mag_y : mag_x;
    mul_a   = '0;
    mul_b   = '0;
    case (cmd.mul_sel)
      dpb_pkg::MUL_D: begin
        mul_a = {17'b0, raw_op};
        mul_b = {1'b0, metre_scale};
      end
      dpb_pkg::MUL_FX: begin
        mul_a = {inv_fx[31], inv_fx};
        mul_b = {13'b0, col_op};
      end
      dpb_pkg::MUL_SK: begin
        mul_a = {skew_term[31], skew_term};
        mul_b = {13'b0, row_op};
      end
      dpb_pkg::MUL_FY: begin
        mul_a = {inv_fy[31], inv_fy};
        mul_b = {13'b0, row_op};
      end
      dpb_pkg::MUL_LL: begin
        mul_a = {1'b0, mag_sel[31:0]};
        mul_b = {1'b0, d_val[23:0]};
      end
      dpb_pkg::MUL_LH: begin
        mul_a = {1'b0, mag_sel[31:0]};
        mul_b = {9'b0, d_val[39:24]};
      end
      dpb_pkg::MUL_HL: begin
        mul_a = {20'b0, mag_sel[44:32]};
        mul_b = {1'b0, d_val[23:0]};
      end
      dpb_pkg::MUL_HH: begin
        mul_a = {20'b0, mag_sel[44:32]};
        mul_b = {9'b0, d_val[39:24]};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // round half away from zero on the magnitude, then saturate
  always_comb begin
    part    = {30'b0, prod[55:0]};
    z_sum   = {1'b0, d_val} + (dpb_pkg::D_W+1)'(128);
    rnd_neg = cmd.coord_y ? neg_y : neg_x;
    rnd_sat = (|acc[85:68]) | acc[67];
    rnd_q   = acc[67:36];
    if (rnd_neg) begin
      rnd_val = rnd_sat ? 32'h8000_0000 : (32'd0 - rnd_q);
    end else begin
      rnd_val = rnd_sat ? 32'h7FFF_FFFF : rnd_q;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.acc_sel)
      dpb_pkg::ACC_D:       d_val <= prod[dpb_pkg::D_W-1:0];
      dpb_pkg::ACC_SX_INIT: sx <= $signed({{14{x_offset[31]}}, x_offset})
                                  + prod[dpb_pkg::S_W-1:0];
      dpb_pkg::ACC_SX_ADD:  sx <= sx + prod[dpb_pkg::S_W-1:0];
      dpb_pkg::ACC_SY_INIT: sy <= $signed({{14{y_offset[31]}}, y_offset})
                                  + prod[dpb_pkg::S_W-1:0];
      dpb_pkg::ACC_ABS: begin
        neg_x <= sx[dpb_pkg::S_W-1];
        neg_y <= sy[dpb_pkg::S_W-1];
        mag_x <= sx[dpb_pkg::S_W-1] ? dpb_pkg::MAG_W'(-sx) : sx[dpb_pkg::MAG_W-1:0];
        mag_y <= sy[dpb_pkg::S_W-1] ? dpb_pkg::MAG_W'(-sy) : sy[dpb_pkg::MAG_W-1:0];
        res_z <= (z_sum[40:39] != 2'b00) ? 32'h7FFF_FFFF : {1'b0, z_sum[38:8]};
      end
      dpb_pkg::ACC_INIT:  acc <= part + (dpb_pkg::ACC_W'(1) << 35);
      dpb_pkg::ACC_ADD24: acc <= acc + (part << 24);
      dpb_pkg::ACC_ADD32: acc <= acc + (part << 32);
      dpb_pkg::ACC_ADD56: acc <= acc + (part << 56);
      dpb_pkg::ACC_RND: begin
        if (cmd.coord_y) begin
          res_y <= rnd_val;
        end else begin
          res_x <= rnd_val;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      point_x     <= ptv_op ? res_x : '0;
      point_y     <= ptv_op ? res_y : '0;
      point_z     <= ptv_op ? res_z : '0;
      point_valid <= ptv_op;
      frame_end   <= last_op;
    end
  end

endmodule
